### rtl/core/owdm_pkg.sv
// ---------------------------------------------------------------------------
// owdm_pkg
// Shared types, constants and arithmetic helpers of the omni-wheel mixer.
// ---------------------------------------------------------------------------
package owdm_pkg;

    localparam int NUM_WHEELS     = 4;
    localparam int DIV_STAGES     = 4;
    localparam int BITS_PER_STAGE = 2;

    localparam logic [7:0] DEADZONE_RESET = 8'd15;
    localparam logic [8:0] SCALE_LIMIT    = 9'd128;
    localparam logic [7:0] SPEED_CAP      = 8'd255;

    // stick axis and mixed wheel value (the latter -384..383)
    typedef logic signed [7:0] axis_t;
    typedef logic signed [9:0] wheel_t;
    typedef logic [8:0]        mag_t;
    typedef logic [7:0]        speed_t;

    // peak stage result
    typedef struct packed {
        logic [NUM_WHEELS-1:0]       neg;
        mag_t [NUM_WHEELS-1:0]       mag;
        mag_t                        peak;
        logic                        scale;
    } mix_beat_t;

    // one divider lane: partial remainder and quotient bits so far
    typedef struct packed {
        mag_t   rem;
        speed_t quo;
    } lane_t;

    typedef struct packed {
        logic [NUM_WHEELS-1:0]       neg;
        mag_t [NUM_WHEELS-1:0]       mag;
        lane_t [NUM_WHEELS-1:0]      lane;
        mag_t                        peak;
        logic                        scale;
    } div_beat_t;

    // zero an axis whose magnitude is below the deadzone
    function automatic axis_t apply_deadzone(axis_t v, logic [7:0] dz);
        logic [7:0] amag;
        amag = v[7] ? 8'(-v) : 8'(v);
        return (amag < dz) ? axis_t'(0) : v;
    endfunction

    function automatic wheel_t widen(axis_t v);
        return {{2{v[7]}}, v};
    endfunction

    function automatic mag_t wheel_mag(wheel_t w);
        logic [9:0] t;
        t = w[9] ? 10'(-w) : 10'(w);
        return t[8:0];
    endfunction

    function automatic mag_t mag_max(mag_t a, mag_t b);
        return (a > b) ? a : b;
    endfunction

    // restoring division, a few quotient bits per call
    function automatic lane_t div_lane(lane_t l, mag_t peak);
        lane_t      r;
        logic [9:0] t;
        r = l;
        for (int s = 0; s < BITS_PER_STAGE; s++)
        begin
            t = {r.rem, 1'b0};
            if (t >= {1'b0, peak})
            begin
                t     = t - {1'b0, peak};
                r.quo = {r.quo[6:0], 1'b1};
            end
            else
            begin
                r.quo = {r.quo[6:0], 1'b0};
            end
            r.rem = t[8:0];
        end
        return r;
    endfunction

    function automatic div_beat_t div_advance(div_beat_t b);
        div_beat_t r;
        r = b;
        for (int k = 0; k < NUM_WHEELS; k++)
        begin
            r.lane[k] = div_lane(b.lane[k], b.peak);
        end
        return r;
    endfunction

    // final duty: scaled quotient or doubled magnitude, saturated
    function automatic speed_t wheel_speed(mag_t mag, speed_t quo, mag_t peak, logic scale);
        speed_t s;
        if (scale)
        begin
            s = (mag == peak) ? SPEED_CAP : quo;
        end
        else
        begin
            s = (mag[8:7] != 2'b00) ? SPEED_CAP : {mag[6:0], 1'b0};
        end
        return s;
    endfunction

endpackage

### rtl/core/owdm_if.sv
// ---------------------------------------------------------------------------
// owdm_if
// Valid/ready channels for joystick samples and motor commands.
// ---------------------------------------------------------------------------
interface owdm_sample_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] lateral;
    logic signed [7:0] forward;
    logic signed [7:0] turn;

    modport source (output valid, output lateral, output forward, output turn, input ready);
    modport sink   (input valid, input lateral, input forward, input turn, output ready);
endinterface

interface owdm_motor_if;
    logic       valid;
    logic       ready;
    logic       dir_one;
    logic [7:0] speed_one;
    logic       dir_two;
    logic [7:0] speed_two;
    logic       dir_three;
    logic [7:0] speed_three;
    logic       dir_four;
    logic [7:0] speed_four;

    modport source (output valid, output dir_one, output speed_one, output dir_two,
                    output speed_two, output dir_three, output speed_three,
                    output dir_four, output speed_four, input ready);
    modport sink   (input valid, input dir_one, input speed_one, input dir_two,
                    input speed_two, input dir_three, input speed_three,
                    input dir_four, input speed_four, output ready);
endinterface

### rtl/core/omni_wheel_drive_mixer_top.sv
// ---------------------------------------------------------------------------
// omni_wheel_drive_mixer_top
// Throughput: one sample per cycle, set by the seven-stage pipeline
// (mix, peak, four divider stages, output register); stalls hold every stage.
// Reset: pipeline empties, deadzone returns to 15; no clearing pass.
// ---------------------------------------------------------------------------
module omni_wheel_drive_mixer_top (
    input  logic        clk,
    input  logic        rst_n,
    owdm_sample_if.sink sample,
    owdm_motor_if.source motor,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata
);
    import owdm_pkg::*;

    logic      [7:0] deadzone_reg;
    mix_beat_t       mix_beat;
    div_beat_t       div_beat;
    logic            mix_valid, mix_ready;
    logic            div_valid, div_ready;
    logic            out_valid_reg, out_valid_next;
    logic            out_en;
    logic   [NUM_WHEELS-1:0] dir_reg, dir_next;
    speed_t          speed_reg [NUM_WHEELS];
    speed_t          speed_next [NUM_WHEELS];

    // deadzone register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadzone_reg <= DEADZONE_RESET;
        end
        else if (cfg_we)
        begin
            deadzone_reg <= cfg_wdata;
        end
    end

    owdm_mix u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .deadzone  (deadzone_reg),
        .in_valid  (sample.valid),
        .in_ready  (sample.ready),
        .lateral   (sample.lateral),
        .forward   (sample.forward),
        .turn      (sample.turn),
        .out_valid (mix_valid),
        .out_ready (mix_ready),
        .out_beat  (mix_beat)
    );

    owdm_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mix_valid),
        .in_ready  (mix_ready),
        .in_beat   (mix_beat),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_beat  (div_beat)
    );

    // final duty and motor order (motors 1..4 take v4, v1, v2, v3)
    always_comb
    begin
        out_en         = !out_valid_reg || motor.ready;
        out_valid_next = out_en ? div_valid : out_valid_reg;
        for (int k = 0; k < NUM_WHEELS; k++)
        begin
            dir_next[k]   = div_beat.neg[(k + NUM_WHEELS - 1) % NUM_WHEELS];
            speed_next[k] = wheel_speed(div_beat.mag[(k + NUM_WHEELS - 1) % NUM_WHEELS],
                                        div_beat.lane[(k + NUM_WHEELS - 1) % NUM_WHEELS].quo,
                                        div_beat.peak, div_beat.scale);
        end
    end

    assign div_ready = out_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_en)
        begin
            dir_reg   <= dir_next;
            speed_reg <= speed_next;
        end
    end

    // output beat
    assign motor.valid       = out_valid_reg;
    assign motor.dir_one     = dir_reg[0];
    assign motor.speed_one   = speed_reg[0];
    assign motor.dir_two     = dir_reg[1];
    assign motor.speed_two   = speed_reg[1];
    assign motor.dir_three   = dir_reg[2];
    assign motor.speed_three = speed_reg[2];
    assign motor.dir_four    = dir_reg[3];
    assign motor.speed_four  = speed_reg[3];

endmodule

### rtl/core/owdm_mix.sv
// ---------------------------------------------------------------------------
// owdm_mix
// Deadzone and wheel mixing stage, then magnitude and peak stage.
// ---------------------------------------------------------------------------
module owdm_mix (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [7:0]            deadzone,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  owdm_pkg::axis_t       lateral,
    input  owdm_pkg::axis_t       forward,
    input  owdm_pkg::axis_t       turn,
    output logic                  out_valid,
    input  logic                  out_ready,
    output owdm_pkg::mix_beat_t   out_beat
);
    import owdm_pkg::*;

    logic      mix_valid_reg, mix_valid_next;
    logic      peak_valid_reg, peak_valid_next;
    logic      mix_en, peak_en;
    wheel_t    w_reg [NUM_WHEELS];
    wheel_t    w_next [NUM_WHEELS];
    mix_beat_t peak_reg, peak_next;
    axis_t     x, y, r;
    mag_t      m01, m23;

    // stall chain
    always_comb
    begin
        peak_en         = !peak_valid_reg || out_ready;
        mix_en          = !mix_valid_reg || peak_en;
        mix_valid_next  = mix_en ? in_valid : mix_valid_reg;
        peak_valid_next = peak_en ? mix_valid_reg : peak_valid_reg;
    end

    assign in_ready  = mix_en;
    assign out_valid = peak_valid_reg;
    assign out_beat  = peak_reg;

    // deadzone and mixing
    always_comb
    begin
        x = apply_deadzone(lateral, deadzone);
        y = apply_deadzone(forward, deadzone);
        r = apply_deadzone(turn, deadzone);
        w_next[0] = -widen(x) + widen(y) - widen(r);
        w_next[1] =  widen(x) + widen(y) - widen(r);
        w_next[2] = -widen(x) + widen(y) + widen(r);
        w_next[3] =  widen(x) + widen(y) + widen(r);
    end

    // magnitudes and peak
    always_comb
    begin
        for (int k = 0; k < NUM_WHEELS; k++)
        begin
            peak_next.neg[k] = w_reg[k][9];
            peak_next.mag[k] = wheel_mag(w_reg[k]);
        end
        m01             = mag_max(peak_next.mag[0], peak_next.mag[1]);
        m23             = mag_max(peak_next.mag[2], peak_next.mag[3]);
        peak_next.peak  = mag_max(m01, m23);
        peak_next.scale = peak_next.peak > SCALE_LIMIT;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mix_valid_reg  <= 1'b0;
            peak_valid_reg <= 1'b0;
        end
        else
        begin
            mix_valid_reg  <= mix_valid_next;
            peak_valid_reg <= peak_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (mix_en)
        begin
            w_reg <= w_next;
        end
        if (peak_en)
        begin
            peak_reg <= peak_next;
        end
    end

endmodule

### rtl/core/owdm_div.sv
// ---------------------------------------------------------------------------
// owdm_div
// Pipelined restoring divider: four lanes, two quotient bits per stage.
// ---------------------------------------------------------------------------
module owdm_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  owdm_pkg::mix_beat_t   in_beat,
    output logic                  out_valid,
    input  logic                  out_ready,
    output owdm_pkg::div_beat_t   out_beat
);
    import owdm_pkg::*;

    logic [DIV_STAGES-1:0] valid_reg, valid_next;
    logic [DIV_STAGES-1:0] en;
    div_beat_t             stage_reg  [DIV_STAGES];
    div_beat_t             stage_next [DIV_STAGES];
    div_beat_t             first_beat;

    // stall chain, last stage first
    always_comb
    begin
        en[DIV_STAGES-1] = !valid_reg[DIV_STAGES-1] || out_ready;
        for (int i = DIV_STAGES - 2; i >= 0; i--)
        begin
            en[i] = !valid_reg[i] || en[i+1];
        end
        valid_next[0] = en[0] ? in_valid : valid_reg[0];
        for (int i = 1; i < DIV_STAGES; i++)
        begin
            valid_next[i] = en[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    // load remainders with the magnitudes
    always_comb
    begin
        first_beat.neg   = in_beat.neg;
        first_beat.mag   = in_beat.mag;
        first_beat.peak  = in_beat.peak;
        first_beat.scale = in_beat.scale;
        for (int k = 0; k < NUM_WHEELS; k++)
        begin
            first_beat.lane[k].rem = in_beat.mag[k];
            first_beat.lane[k].quo = '0;
        end
    end

    // divider steps
    always_comb
    begin
        stage_next[0] = div_advance(first_beat);
        for (int i = 1; i < DIV_STAGES; i++)
        begin
            stage_next[i] = div_advance(stage_reg[i-1]);
        end
    end

    assign in_ready  = en[0];
    assign out_valid = valid_reg[DIV_STAGES-1];
    assign out_beat  = stage_reg[DIV_STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DIV_STAGES; i++)
        begin
            if (en[i])
            begin
                stage_reg[i] <= stage_next[i];
            end
        end
    end

endmodule

### tb/sv/tb.sv
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the omni-wheel drive mixer. A directed table covers
// stick extremes, the deadzone edges and the peak-of-128 boundary, then random
// samples run through several deadzone settings. Every motor beat is compared
// lane by lane with a typed answer or a local model of the mixing and scaling math.
// ---------------------------------------------------------------------------
module tb;
    import owdm_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 93;
    localparam int TAIL_CYCLES = 20;
    localparam int PLAN_ROWS   = 25;

    // one motor command, motor one in the top lane, each lane {dir, speed}
    typedef logic [35:0] motor_cmd_t;

    // directed row: either a deadzone write or a sample, optionally with a typed answer
    typedef struct packed {
        logic       cfg;
        logic [7:0] dz;
        axis_t      lat;
        axis_t      fwd;
        axis_t      trn;
        logic       typed;
        motor_cmd_t want;
    } plan_row_t;

    localparam motor_cmd_t ALL_STOP = '0;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we;
    logic [7:0] cfg_wdata;

    owdm_sample_if sample_ch ();
    owdm_motor_if  motor_ch ();

    motor_cmd_t motor_due [$];
    logic [7:0] dz_now = DEADZONE_RESET;
    int         mismatches = 0;
    int         idle_cycles = 0;
    logic       steady = 1'b0;
    logic       hold_ask = 1'b0;

    plan_row_t plan [PLAN_ROWS] = '{
        // reset deadzone of 15
        '{0, 0, 0, 0, 0, 1, ALL_STOP},
        '{0, 0, 10, -14, 14, 1, ALL_STOP},
        '{0, 0, 127, 0, 0, 1, {1'b0, 8'd254, 1'b1, 8'd254, 1'b0, 8'd254, 1'b1, 8'd254}},
        '{0, 0, -128, 0, 0, 1, {1'b1, 8'd255, 1'b0, 8'd255, 1'b1, 8'd255, 1'b0, 8'd255}},
        '{0, 0, 127, 127, 127, 1, {1'b0, 8'd255, 1'b1, 8'd85, 1'b0, 8'd85, 1'b0, 8'd85}},
        '{0, 0, -128, -128, -128, 1, {1'b1, 8'd255, 1'b0, 8'd85, 1'b1, 8'd85, 1'b1, 8'd85}},
        '{0, 0, 0, 127, 0, 1, {1'b0, 8'd254, 1'b0, 8'd254, 1'b0, 8'd254, 1'b0, 8'd254}},
        '{0, 0, 0, 0, -128, 1, {1'b1, 8'd255, 1'b0, 8'd255, 1'b0, 8'd255, 1'b1, 8'd255}},
        // peak of exactly 128 saturates, zero wheels stay zero
        '{0, 0, 64, 64, 0, 1, {1'b0, 8'd255, 1'b0, 8'd0, 1'b0, 8'd255, 1'b0, 8'd0}},
        '{0, 0, 64, 65, 0, 0, ALL_STOP},
        '{0, 0, -37, 90, 55, 0, ALL_STOP},
        '{0, 0, 15, -15, -14, 0, ALL_STOP},
        '{0, 0, 14, -128, 127, 0, ALL_STOP},
        // deadzone off
        '{1, 0, 0, 0, 0, 0, ALL_STOP},
        '{0, 0, 1, -1, 1, 1, {1'b0, 8'd2, 1'b1, 8'd6, 1'b1, 8'd2, 1'b1, 8'd2}},
        '{0, 0, -1, 0, 0, 0, ALL_STOP},
        // top of range: only full-scale negative survives
        '{1, 128, 0, 0, 0, 0, ALL_STOP},
        '{0, 0, -128, 127, -127, 1, {1'b1, 8'd255, 1'b0, 8'd255, 1'b1, 8'd255, 1'b0, 8'd255}},
        '{0, 0, 127, -128, 5, 0, ALL_STOP},
        // above range: everything zeroed
        '{1, 255, 0, 0, 0, 0, ALL_STOP},
        '{0, 0, -128, -128, -128, 1, ALL_STOP},
        '{0, 0, 127, 127, 127, 1, ALL_STOP},
        '{1, 129, 0, 0, 0, 0, ALL_STOP},
        '{0, 0, -128, 127, -128, 1, ALL_STOP},
        '{1, 15, 0, 0, 0, 0, ALL_STOP}
    };

    omni_wheel_drive_mixer_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample_ch),
        .motor     (motor_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    // deadzone, mix, then scale or double each wheel magnitude
    function automatic motor_cmd_t mix_predict(axis_t lat, axis_t fwd, axis_t trn,
                                               logic [7:0] dz);
        int         ax [3];
        int         w [4];
        int         peak;
        int         mag;
        int         spd;
        int         src;
        motor_cmd_t c;
        ax[0] = lat;
        ax[1] = fwd;
        ax[2] = trn;
        foreach (ax[i])
        begin
            if ((ax[i] < 0 ? -ax[i] : ax[i]) < int'(dz))
                ax[i] = 0;
        end
        w[0] = -ax[0] + ax[1] - ax[2];
        w[1] =  ax[0] + ax[1] - ax[2];
        w[2] = -ax[0] + ax[1] + ax[2];
        w[3] =  ax[0] + ax[1] + ax[2];
        peak = 0;
        foreach (w[i])
        begin
            mag = w[i] < 0 ? -w[i] : w[i];
            if (mag > peak)
                peak = mag;
        end
        // motors one to four are fed from v4, v1, v2, v3
        for (int k = 0; k < NUM_WHEELS; k++)
        begin
            src = (k == 0) ? 3 : k - 1;
            mag = w[src] < 0 ? -w[src] : w[src];
            spd = (peak > int'(SCALE_LIMIT)) ? (mag * 256) / peak : mag * 2;
            if (spd > int'(SPEED_CAP))
                spd = int'(SPEED_CAP);
            c[35 - 9 * k -: 9] = {w[src] < 0, 8'(spd)};
        end
        return c;
    endfunction

    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    endfunction

    // full range mostly, some near the deadzone threshold, some extremes
    function automatic axis_t pick_axis(logic [7:0] dz);
        int roll;
        int mag;
        roll = $urandom_range(0, 9);
        if (roll < 6)
            return axis_t'($urandom_range(0, 255));
        if (roll < 8)
        begin
            mag = int'(dz) - 1 + int'($urandom_range(0, 2));
            if (mag < 0)
                mag = 0;
            if (mag > 128)
                mag = 128;
            return ($urandom_range(0, 1) == 1 || mag == 128) ? axis_t'(-mag) : axis_t'(mag);
        end
        case ($urandom_range(0, 4))
            0: return axis_t'(-128);
            1: return axis_t'(127);
            2: return axis_t'(-1);
            3: return axis_t'(1);
            default: return axis_t'(0);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // offer one sample beat and hold it until accepted
    task automatic send_sample(input axis_t lat, input axis_t fwd, input axis_t trn,
                               input logic typed, input motor_cmd_t want);
        sample_ch.valid   <= 1'b1;
        sample_ch.lateral <= lat;
        sample_ch.forward <= fwd;
        sample_ch.turn    <= trn;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        motor_due.push_back(typed ? want : mix_predict(lat, fwd, trn, dz_now));
    endtask

    task automatic idle_gap();
        int n;
        if (!steady && $urandom_range(0, 99) < 30)
        begin
            n = gap_len();
            sample_ch.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // an empty queue means valid is already low after an idle gap
    task automatic drain();
        if (motor_due.size() != 0)
        begin
            sample_ch.valid <= 1'b0;
            while (motor_due.size() != 0)
                @(posedge clk);
        end
    endtask

    task automatic write_deadzone(input logic [7:0] value);
        drain();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        dz_now = value;
    endtask

    // stimulus: directed table, then random phases over several deadzones
    initial
    begin : stim
        logic [7:0] zones [7];
        sample_ch.valid   = 1'b0;
        sample_ch.lateral = '0;
        sample_ch.forward = '0;
        sample_ch.turn    = '0;
        cfg_we            = 1'b0;
        cfg_wdata         = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].cfg)
                write_deadzone(plan[i].dz);
            else
            begin
                send_sample(plan[i].lat, plan[i].fwd, plan[i].trn, plan[i].typed, plan[i].want);
                idle_gap();
            end
        end

        zones = '{8'd0, 8'd15, 8'd128, 8'd255, 8'($urandom_range(1, 127)), 8'd129,
                  8'($urandom_range(0, 255))};
        foreach (zones[p])
        begin
            write_deadzone(zones[p]);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // back-to-back stretch with no idling on either side
                if (p == 1)
                    steady = (n < PHASE_ITEMS / 2);
                // long receiver hold-off while samples keep coming
                if (p == 2 && n == 10)
                begin
                    steady = 1'b1;
                    hold_ask <= 1'b1;
                end
                if (p == 2 && n == 40)
                    steady = 1'b0;
                // sender pauses until the pipeline is empty
                if (p == 4 && n == PHASE_ITEMS / 2)
                    drain();
                send_sample(pick_axis(dz_now), pick_axis(dz_now), pick_axis(dz_now),
                            1'b0, ALL_STOP);
                idle_gap();
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // motor side ready: random gaps, one long hold-off on request
    initial
    begin : sink
        int  stall_left;
        logic hold_taken;
        stall_left     = 0;
        hold_taken     = 1'b0;
        motor_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!rst_n)
                motor_ch.ready <= 1'b0;
            else if (hold_ask && !hold_taken)
            begin
                hold_taken     = 1'b1;
                stall_left     = HOLD_CYCLES - 1;
                motor_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                motor_ch.ready <= 1'b0;
            end
            else if (!steady && $urandom_range(0, 99) < 25)
            begin
                stall_left     = gap_len() - 1;
                motor_ch.ready <= 1'b0;
            end
            else
                motor_ch.ready <= 1'b1;
        end
    end

    // compare each motor beat against the oldest owed command
    always @(posedge clk)
    begin : check
        motor_cmd_t got;
        motor_cmd_t want;
        if (rst_n && motor_ch.valid && motor_ch.ready)
        begin
            got = {motor_ch.dir_one, motor_ch.speed_one, motor_ch.dir_two, motor_ch.speed_two,
                   motor_ch.dir_three, motor_ch.speed_three,
                   motor_ch.dir_four, motor_ch.speed_four};
            if (motor_due.size() == 0)
                report_mismatch("motor beat with nothing owed", 1, 0);
            else
            begin
                want = motor_due.pop_front();
                for (int k = 0; k < NUM_WHEELS; k++)
                begin
                    if (got[35 - 9 * k] !== want[35 - 9 * k])
                        report_mismatch($sformatf("motor %0d dir", k + 1),
                                        got[35 - 9 * k], want[35 - 9 * k]);
                    if (got[34 - 9 * k -: 8] !== want[34 - 9 * k -: 8])
                        report_mismatch($sformatf("motor %0d speed", k + 1),
                                        got[34 - 9 * k -: 8], want[34 - 9 * k -: 8]);
                end
            end
        end
    end

    // watchdog: too long without any beat on either channel
    always @(posedge clk)
    begin
        if ((sample_ch.valid && sample_ch.ready) || (motor_ch.valid && motor_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

endmodule
